// ----- design/bgbr_pkg.sv -----
package bgbr_pkg;

	localparam int MAX_PAIRS = 1024;
	localparam int PAIR_W    = $clog2(MAX_PAIRS);
	localparam int CNT_W     = PAIR_W + 1;
	localparam int PIX_W     = 8;
	localparam int CFG_W     = 11;

	localparam logic [CFG_W-1:0] PAIRS_RESET = CFG_W'(320);
	localparam logic [CFG_W-1:0] PAIRS_MAX   = CFG_W'(MAX_PAIRS);

	// beat position within one 2x2 block: {lower_row, right_column}
	localparam logic [1:0] FIRST_BEAT = 2'd0;
	localparam logic [1:0] LAST_BEAT  = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0]  red;
		logic [PIX_W-1:0]  green_upper;
		logic [PIX_W-1:0]  green_lower;
		logic [PIX_W-1:0]  blue;
		logic [PAIR_W-1:0] pair;
	} block_t;

endpackage

// ----- design/bgbr_front.sv -----
module bgbr_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [bgbr_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [bgbr_pkg::PIX_W-1:0]         raw_pixel,
	input  logic                               frame_start,
	output logic                               blk_valid,
	input  logic                               blk_ready,
	output bgbr_pkg::block_t                   blk
);

	localparam int CW = bgbr_pkg::CNT_W;
	localparam int PW = bgbr_pkg::PAIR_W;
	localparam int XW = bgbr_pkg::PIX_W;

	logic [bgbr_pkg::CFG_W-1:0] pairs_q;
	logic [bgbr_pkg::CFG_W-1:0] pairs_eff;
	logic [CW:0]                line_end;
	logic [CW-1:0]              col_q;
	logic                       odd_q;
	logic [XW-1:0]              held_red_q;
	logic [XW-1:0]              held_green_q;

	logic [CW-1:0] col_eff;
	logic          odd_eff;
	logic [PW-1:0] pair;
	logic          phase;
	logic [CW:0]   col_inc;
	logic          acc, we, emit;

	logic [2*XW-1:0] line_mem [bgbr_pkg::MAX_PAIRS];
	logic [2*XW-1:0] rd_q;

	logic          valid_s1;
	logic [XW-1:0] red_s1;
	logic [XW-1:0] green_low_s1;
	logic [PW-1:0] pair_s1;

	// width clamp: zero acts as one pair, above the store depth saturates
	always_comb begin
		if (pairs_q == '0) begin
			pairs_eff = bgbr_pkg::CFG_W'(1);
		end else if (pairs_q > bgbr_pkg::PAIRS_MAX) begin
			pairs_eff = bgbr_pkg::PAIRS_MAX;
		end else begin
			pairs_eff = pairs_q;
		end
	end

	assign line_end = {(CW+1-bgbr_pkg::CFG_W)'(0), pairs_eff} << 1;

	assign col_eff = frame_start ? '0 : col_q;
	assign odd_eff = frame_start ? 1'b0 : odd_q;
	assign pair    = col_eff[CW-1:1];
	assign phase   = col_eff[0];
	assign col_inc = {1'b0, col_eff} + (CW+1)'(1);

	assign in_ready = !valid_s1 || blk_ready;
	assign acc      = in_valid && in_ready;
	assign we       = acc && !odd_eff && phase;
	assign emit     = acc && odd_eff && phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_q      <= bgbr_pkg::PAIRS_RESET;
			col_q        <= '0;
			odd_q        <= 1'b0;
			held_red_q   <= '0;
			held_green_q <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				pairs_q <= cfg_data;
			end
			if (acc) begin
				if (col_inc >= line_end) begin
					col_q <= '0;
					odd_q <= !odd_eff;
				end else begin
					col_q <= col_inc[CW-1:0];
					odd_q <= odd_eff;
				end
				if (!phase && odd_eff) begin
					held_red_q <= raw_pixel;
				end
				if (!phase && !odd_eff) begin
					held_green_q <= raw_pixel;
				end
			end
			if (emit) begin
				valid_s1 <= 1'b1;
			end else if (blk_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// line store: green high byte, blue low byte
	always_ff @(posedge clk) begin
		if (we) begin
			line_mem[pair] <= {held_green_q, raw_pixel};
		end
		if (emit) begin
			rd_q <= line_mem[pair];
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			red_s1       <= held_red_q;
			green_low_s1 <= raw_pixel;
			pair_s1      <= pair;
		end
	end

	assign blk_valid       = valid_s1;
	assign blk.red         = red_s1;
	assign blk.green_upper = rd_q[2*XW-1:XW];
	assign blk.green_lower = green_low_s1;
	assign blk.blue        = rd_q[XW-1:0];
	assign blk.pair        = pair_s1;

endmodule

// ----- design/bgbr_expand.sv -----
module bgbr_expand (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         blk_valid,
	output logic                         blk_ready,
	input  bgbr_pkg::block_t             blk,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bgbr_pkg::PIX_W-1:0]   red,
	output logic [bgbr_pkg::PIX_W-1:0]   green,
	output logic [bgbr_pkg::PIX_W-1:0]   blue,
	output logic                         lower_row,
	output logic                         right_column,
	output logic [bgbr_pkg::PAIR_W-1:0]  pair_index,
	output logic                         last_of_block
);

	logic             valid_q;
	logic [1:0]       beat_q;
	bgbr_pkg::block_t blk_q;
	logic             last;

	assign last      = beat_q == bgbr_pkg::LAST_BEAT;
	assign blk_ready = !valid_q || (out_ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= bgbr_pkg::FIRST_BEAT;
		end else if (blk_valid && blk_ready) begin
			valid_q <= 1'b1;
			beat_q  <= bgbr_pkg::FIRST_BEAT;
		end else if (valid_q && out_ready) begin
			beat_q <= beat_q + 2'd1;
			if (last) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (blk_valid && blk_ready) begin
			blk_q <= blk;
		end
	end

	assign out_valid     = valid_q;
	assign red           = blk_q.red;
	assign green         = beat_q[1] ? blk_q.green_lower : blk_q.green_upper;
	assign blue          = blk_q.blue;
	assign lower_row     = beat_q[1];
	assign right_column  = beat_q[0];
	assign pair_index    = blk_q.pair;
	assign last_of_block = last;

endmodule

// ----- design/bayer_gbrg_block_replicate_demosaic_unit.sv -----
// channel | signals                                  | dir | beat
// --------+------------------------------------------+-----+-------------------------------
// cfg     | cfg_valid cfg_ready cfg_data[10:0]       | in  | pairs_per_line write
// in      | in_valid in_ready raw_pixel frame_start  | in  | one Bayer sample, raster order
// out     | out_valid out_ready red green blue       | out | one RGB pixel of a 2x2 block
//         | lower_row right_column pair_index        |     |
//         | last_of_block                            |     |
//
// Even-row samples go in one per cycle while in_ready is high; each odd-row green
// sample finishes a block that the expander sends as four out beats, so odd-row
// input waits on the expander; a block passes the front and expander registers.
// Reset clears counters, held samples and valid flags; the line store is not
// cleared and holds nothing meaningful until an even row writes it.
// A stalled out port holds its beat; input stops once a second block is waiting.
module bayer_gbrg_block_replicate_demosaic_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bgbr_pkg::CFG_W-1:0]   cfg_data,
	// raw samples
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bgbr_pkg::PIX_W-1:0]   raw_pixel,
	input  logic                         frame_start,
	// RGB pixels
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bgbr_pkg::PIX_W-1:0]   red,
	output logic [bgbr_pkg::PIX_W-1:0]   green,
	output logic [bgbr_pkg::PIX_W-1:0]   blue,
	output logic                         lower_row,
	output logic                         right_column,
	output logic [bgbr_pkg::PAIR_W-1:0]  pair_index,
	output logic                         last_of_block
);

	logic             blk_valid;
	logic             blk_ready;
	bgbr_pkg::block_t blk;

	// the width register is always writable
	assign cfg_ready = 1'b1;

	// counters, line store and the one-block stage
	bgbr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.raw_pixel   (raw_pixel),
		.frame_start (frame_start),
		.blk_valid   (blk_valid),
		.blk_ready   (blk_ready),
		.blk         (blk)
	);

	// one block in, four pixels out: UL, UR, LL, LR
	bgbr_expand u_expand (
		.clk           (clk),
		.arst_n        (arst_n),
		.blk_valid     (blk_valid),
		.blk_ready     (blk_ready),
		.blk           (blk),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.lower_row     (lower_row),
		.right_column  (right_column),
		.pair_index    (pair_index),
		.last_of_block (last_of_block)
	);

endmodule

// ----- design/bgbr_checker.sv -----
module bgbr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [bgbr_pkg::PIX_W-1:0]   red,
	input logic [bgbr_pkg::PIX_W-1:0]   green,
	input logic [bgbr_pkg::PIX_W-1:0]   blue,
	input logic                         lower_row,
	input logic                         right_column,
	input logic [bgbr_pkg::PAIR_W-1:0]  pair_index,
	input logic                         last_of_block
);

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue) && $stable(pair_index) && $stable(lower_row)
			&& $stable(right_column))
		else $error("out beat changed while stalled");

	// last flag marks exactly the lower right pixel
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_of_block == (lower_row && right_column))
		else $error("last_of_block not on lower right pixel");

	// beats of one block follow without a gap, same pair, red and blue
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_block |=> out_valid && $stable(pair_index)
			&& $stable(red) && $stable(blue))
		else $error("block burst broken");

	// left pixel is followed by the right pixel of the same row
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !right_column |=> right_column && $stable(lower_row))
		else $error("pixel order within block wrong");

endmodule

bind bayer_gbrg_block_replicate_demosaic_unit bgbr_checker u_bgbr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.red           (red),
	.green         (green),
	.blue          (blue),
	.lower_row     (lower_row),
	.right_column  (right_column),
	.pair_index    (pair_index),
	.last_of_block (last_of_block)
);

// ----- tb/tb_bayer_gbrg_block_replicate_demosaic_unit.sv -----
`timescale 1ns / 100ps

module tb_bayer_gbrg_block_replicate_demosaic_unit;

	// no accepted beat on any channel for this many cycles ends the run
	localparam int STALL_LIMIT   = 2000;
	// out port hold-off used to back the block up into its input
	localparam int HOLD_CYCLES   = 60;
	// settle time after the last RGB beat before a width write
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_PCT      = 26;
	localparam int N_DIRECTED    = 24;
	localparam int N_PHASES      = 7;
	localparam int PHASE_ITEMS   = 18;
	localparam int MAX_REPORTS   = 10;

	typedef enum logic {ROW_SAMPLE, ROW_WIDTH} row_kind_t;

	// one RGB out beat, as seen on the out port
	typedef struct packed {
		logic [bgbr_pkg::PIX_W-1:0]  red;
		logic [bgbr_pkg::PIX_W-1:0]  green;
		logic [bgbr_pkg::PIX_W-1:0]  blue;
		logic                        lower_row;
		logic                        right_column;
		logic [bgbr_pkg::PAIR_W-1:0] pair_index;
		logic                        last_of_block;
	} rgb_beat_t;

	// travels with each raw sample; a typed block replaces the prediction
	typedef struct packed {
		logic             typed;
		bgbr_pkg::block_t blk;
	} sample_tag_t;

	typedef struct packed {
		row_kind_t                  kind;
		logic [bgbr_pkg::CFG_W-1:0] width;
		logic [bgbr_pkg::PIX_W-1:0] px;
		logic                       fs;
		logic                       typed;
		bgbr_pkg::block_t           blk;
	} dir_row_t;

	localparam bgbr_pkg::block_t NO_BLOCK = '0;

	// Directed rows. Block fields are {red, green_upper, green_lower, blue, pair}.
	// Starts at the reset width (320 pairs) without frame_start, then shrinks
	// the line while the column count is already past the new end, runs a
	// zero width (acts as one pair), and restarts frames on both row kinds.
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		'{ROW_SAMPLE, 11'd0, 8'h00, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'hFF, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'h12, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'h34, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'h56, 1'b0, 1'b0, NO_BLOCK},
		// column 5, new end at 4: line ends after the next sample
		'{ROW_WIDTH,  11'd2, 8'h00, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'h9A, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'hFF, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'h00, 1'b0, 1'b1, '{8'hFF, 8'h00, 8'h00, 8'hFF, 10'd0}},
		'{ROW_SAMPLE, 11'd0, 8'h00, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'hFF, 1'b0, 1'b1, '{8'h00, 8'h12, 8'hFF, 8'h34, 10'd1}},
		'{ROW_WIDTH,  11'd0, 8'h00, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'hA5, 1'b1, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'h5A, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'hC3, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'h3C, 1'b0, 1'b1, '{8'hC3, 8'hA5, 8'h3C, 8'h5A, 10'd0}},
		// frame restart on an even row, then on an odd row after its red
		'{ROW_SAMPLE, 11'd0, 8'h11, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'h22, 1'b1, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'h33, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'h44, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'h55, 1'b1, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'h66, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'h77, 1'b0, 1'b0, NO_BLOCK},
		'{ROW_SAMPLE, 11'd0, 8'h88, 1'b0, 1'b0, NO_BLOCK}
	};

	logic                        clk;
	logic                        arst_n        = 1'b0;
	logic                        cfg_valid     = 1'b0;
	logic                        cfg_ready;
	logic [bgbr_pkg::CFG_W-1:0]  cfg_data      = '0;
	logic                        in_valid      = 1'b0;
	logic                        in_ready;
	logic [bgbr_pkg::PIX_W-1:0]  raw_pixel     = '0;
	logic                        frame_start   = 1'b0;
	logic                        out_valid;
	logic                        out_ready     = 1'b0;
	logic [bgbr_pkg::PIX_W-1:0]  red;
	logic [bgbr_pkg::PIX_W-1:0]  green;
	logic [bgbr_pkg::PIX_W-1:0]  blue;
	logic                        lower_row;
	logic                        right_column;
	logic [bgbr_pkg::PAIR_W-1:0] pair_index;
	logic                        last_of_block;

	// demosaic predictor state, advanced on each accepted beat
	logic [15:0]                 gb_line    [bgbr_pkg::MAX_PAIRS];
	logic                        gb_written [bgbr_pkg::MAX_PAIRS] = '{default: 1'b0};
	int                          col_count  = 0;
	logic                        on_odd_row = 1'b0;
	logic [bgbr_pkg::PIX_W-1:0]  held_red   = '0;
	logic [bgbr_pkg::PIX_W-1:0]  held_green = '0;
	logic [bgbr_pkg::CFG_W-1:0]  width_pairs = bgbr_pkg::PAIRS_RESET;

	rgb_beat_t           rgb_expected [$];
	sample_tag_t         block_tags [$];

	int                  samples_taken = 0;
	int                  widths_taken  = 0;
	int                  mismatches    = 0;
	int                  stall_cycles  = 0;

	// traffic shaping shared by sender and receiver
	logic                steady    = 1'b0;
	int                  hold_req  = 0;
	int                  hold_seen = 0;
	int                  hold_left = 0;

	bayer_gbrg_block_replicate_demosaic_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.raw_pixel     (raw_pixel),
		.frame_start   (frame_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.lower_row     (lower_row),
		.right_column  (right_column),
		.pair_index    (pair_index),
		.last_of_block (last_of_block)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Four beats of one 2x2 block: upper left, upper right, lower left,
	// lower right. Red and blue are replicated; each row keeps its own green.
	function automatic void expect_block(input bgbr_pkg::block_t b);
		rgb_beat_t  beat;
		logic [1:0] pos;
		for (int k = int'(bgbr_pkg::FIRST_BEAT); k <= int'(bgbr_pkg::LAST_BEAT); k++) begin
			pos                = 2'(k);
			beat.red           = b.red;
			beat.green         = pos[1] ? b.green_lower : b.green_upper;
			beat.blue          = b.blue;
			beat.lower_row     = pos[1];
			beat.right_column  = pos[0];
			beat.pair_index    = b.pair;
			beat.last_of_block = (pos == bgbr_pkg::LAST_BEAT);
			rgb_expected.push_back(beat);
		end
	endfunction

	// Advances the demosaic state by one raw sample. Returns 1 when the
	// sample is the green of an odd-row pair, with the finished block in blk.
	function automatic logic demosaic_sample(input logic [bgbr_pkg::PIX_W-1:0] px,
			input logic fs, output bgbr_pkg::block_t blk);
		int   pairs;
		int   pair;
		int   slot;
		logic done;
		if (width_pairs == '0)
			pairs = 1;
		else if (width_pairs > bgbr_pkg::PAIRS_MAX)
			pairs = bgbr_pkg::MAX_PAIRS;
		else
			pairs = int'(width_pairs);
		done = 1'b0;
		blk  = '0;
		if (fs) begin
			col_count  = 0;
			on_odd_row = 1'b0;
		end
		pair = col_count >> 1;
		slot = (pair < bgbr_pkg::MAX_PAIRS) ? pair : bgbr_pkg::MAX_PAIRS - 1;
		if (!on_odd_row) begin
			if ((col_count & 1) == 0) begin
				held_green = px;
			end else begin
				gb_line[slot]    = {held_green, px};
				gb_written[slot] = 1'b1;
			end
		end else if ((col_count & 1) == 0) begin
			held_red = px;
		end else begin
			blk.red         = held_red;
			blk.green_upper = gb_line[slot][15:8];
			blk.green_lower = px;
			blk.blue        = gb_line[slot][7:0];
			blk.pair        = pair[bgbr_pkg::PAIR_W-1:0];
			done            = 1'b1;
		end
		col_count++;
		if (col_count >= 2 * pairs) begin
			col_count  = 0;
			on_odd_row = !on_odd_row;
		end
		return done;
	endfunction

	// Sample on the rising edge: out beats are checked before the input beat
	// of the same edge is predicted, since a block passes the front and expander registers first.
	always @(posedge clk) begin : monitor
		rgb_beat_t        got;
		rgb_beat_t        want;
		sample_tag_t      tag;
		bgbr_pkg::block_t blk;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{red, green, blue, lower_row, right_column, pair_index,
					last_of_block};
				if (rgb_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: RGB beat with none pending: r=%02h g=%02h b=%02h",
							$time, got.red, got.green, got.blue,
							" low=%0b right=%0b pair=%0d last=%0b", got.lower_row,
							got.right_column, got.pair_index, got.last_of_block);
				end else begin
					want = rgb_expected.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t: RGB beat mismatch", $time);
							$display("  expected r=%02h g=%02h b=%02h low=%0b right=%0b",
								want.red, want.green, want.blue, want.lower_row,
								want.right_column, " pair=%0d last=%0b",
								want.pair_index, want.last_of_block);
							$display("  actual   r=%02h g=%02h b=%02h low=%0b right=%0b",
								got.red, got.green, got.blue, got.lower_row,
								got.right_column, " pair=%0d last=%0b",
								got.pair_index, got.last_of_block);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				tag = block_tags.pop_front();
				if (demosaic_sample(raw_pixel, frame_start, blk) && !tag.typed)
					expect_block(blk);
				if (tag.typed)
					expect_block(tag.blk);
				samples_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				width_pairs = cfg_data;
				widths_taken++;
			end
		end
	end

	// Receiver: random back-pressure, a requested long hold-off, none when steady.
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog on handshake progress across all three channels.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_bayer_gbrg_block_replicate_demosaic_unit NOT OK");
			$finish;
		end
	end

	// Offers one raw sample and returns at the falling edge after it is taken.
	// A frame restart is forced where the sample would read a line store
	// entry that no even row has filled yet.
	task automatic push_sample(input logic [bgbr_pkg::PIX_W-1:0] px, input logic fs,
			input logic typed, input bgbr_pkg::block_t blk);
		int          seen;
		int          slot;
		sample_tag_t tag;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		slot = ((col_count >> 1) < bgbr_pkg::MAX_PAIRS) ? (col_count >> 1)
			: bgbr_pkg::MAX_PAIRS - 1;
		if (!fs && on_odd_row && (col_count & 1) != 0 && !gb_written[slot])
			fs = 1'b1;
		tag.typed = typed;
		tag.blk   = blk;
		block_tags.push_back(tag);
		in_valid    <= 1'b1;
		raw_pixel   <= px;
		frame_start <= fs;
		seen = samples_taken;
		do @(negedge clk); while (samples_taken == seen);
	endtask

	// Drops the input and waits for every pending RGB beat.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (rgb_expected.size() != 0);
	endtask

	task automatic set_width(input logic [bgbr_pkg::CFG_W-1:0] w);
		int seen;
		wait_drained();
		// a sample with no result may still be in flight
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		seen = widths_taken;
		do @(negedge clk); while (widths_taken == seen);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int               phase_w [N_PHASES];
		logic             fs;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows, first ones at the reset width
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].kind == ROW_WIDTH)
				set_width(DIRECTED[i].width);
			else
				push_sample(DIRECTED[i].px, DIRECTED[i].fs, DIRECTED[i].typed,
					DIRECTED[i].blk);
		end

		// random phases at small widths, zero among them; the third runs
		// with no idling on either side
		phase_w = '{1, 3, 2, 0, 7, 4, 1};
		phase_w[N_PHASES-1] = $urandom_range(1, 12);
		for (int ph = 0; ph < N_PHASES; ph++) begin
			set_width(bgbr_pkg::CFG_W'(phase_w[ph]));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// back the out port up while samples keep coming
				if (ph == 1 && k == 4)
					hold_req++;
				if (ph == 4 && k == PHASE_ITEMS / 2)
					wait_drained();
				steady = (ph == 2);
				// mostly clean frames; a stray frame_start now and then
				fs = (k == 0) || ($urandom_range(99) < 3);
				push_sample(bgbr_pkg::PIX_W'($urandom_range(255)), fs, 1'b0, NO_BLOCK);
			end
			steady = 1'b0;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && rgb_expected.size() == 0)
			$display("tb_bayer_gbrg_block_replicate_demosaic_unit OK");
		else
			$display("tb_bayer_gbrg_block_replicate_demosaic_unit NOT OK");
		$finish;
	end

endmodule
